// File: hw/rtl/vboe_pkg.sv
// Shared types, constants and register codes of the voxel brick occupancy encoder.
`default_nettype none

package vboe_pkg;

	localparam int VOXEL_BITS_DEF = 16;
	localparam int BRICK_SIDE_DEF = 4;

	localparam int VOXEL_W = 16;
	localparam int INDEX_W = 6;
	localparam int MASK_W  = 64;
	localparam int COUNT_W = 7;
	localparam int FLAGS_W = 2;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	localparam logic KIND_PACKED  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [FLAGS_W-1:0] FLAGS_UNIFORM = 2'd3;
	localparam logic [FLAGS_W-1:0] FLAGS_LIST    = 2'd1;

	localparam logic REG_EMPTY_CODE = 1'b0;

	typedef struct packed {
		logic                kind;
		logic [VOXEL_W-1:0]  packed_value;
		logic [INDEX_W-1:0]  packed_index;
		logic [MASK_W-1:0]   occupancy;
		logic [COUNT_W-1:0]  occupied_count;
		logic                single_material;
		logic [VOXEL_W-1:0]  brick_material;
		logic [FLAGS_W-1:0]  node_flags;
		logic                last;
	} vboe_result_t;

	typedef struct packed {
		logic [1:0]   n;
		vboe_result_t first;
		vboe_result_t second;
	} vboe_push_t;

endpackage

`default_nettype wire

// File: hw/rtl/vboe_if.sv
// Valid/ready channel interfaces for voxel input and encoder results.
`default_nettype none

interface vboe_voxel_if;
	logic        valid;
	logic        ready;
	logic [15:0] voxel;

	modport source (output valid, output voxel, input ready);
	modport sink (input valid, input voxel, output ready);
endinterface

interface vboe_result_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] packed_value;
	logic [5:0]  packed_index;
	logic [63:0] occupancy;
	logic [6:0]  occupied_count;
	logic        single_material;
	logic [15:0] brick_material;
	logic [1:0]  node_flags;
	logic        last;

	modport source (output valid, output kind, output packed_value, output packed_index,
		output occupancy, output occupied_count, output single_material,
		output brick_material, output node_flags, output last, input ready);
	modport sink (input valid, input kind, input packed_value, input packed_index,
		input occupancy, input occupied_count, input single_material,
		input brick_material, input node_flags, input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/voxel_brick_occupancy_encoder.sv
// Voxel brick occupancy encoder: one voxel per transfer, packed entries and a brick summary.
// Throughput: one voxel per cycle while the result queue has room; the last voxel of a
// brick yields up to two results. Results are written to the registered queue first.
// Results leave one per cycle while the sink is ready; a fully occupied brick yields 65 results.
// Reset clears the brick state, the empty code and the result queue; there is no clearing pass.
`default_nettype none

module voxel_brick_occupancy_encoder
	import vboe_pkg::*;
#(
	parameter int VOXEL_BITS = VOXEL_BITS_DEF,
	parameter int BRICK_SIDE = BRICK_SIDE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	vboe_voxel_if.sink       voxels,
	vboe_result_if.source    results
);

	localparam int CELLS = BRICK_SIDE * BRICK_SIDE * BRICK_SIDE;
	localparam logic [INDEX_W-1:0] LAST_POS = INDEX_W'(CELLS - 1);
	localparam logic [VOXEL_W-1:0] VMASK =
		(VOXEL_BITS >= VOXEL_W) ? {VOXEL_W{1'b1}} : VOXEL_W'((64'd1 << VOXEL_BITS) - 64'd1);

	logic [VOXEL_W-1:0] empty_code_q;
	logic [INDEX_W-1:0] position_q;
	logic [MASK_W-1:0]  mask_q;
	logic [VOXEL_W-1:0] first_q;
	logic               still_uniform_q;
	logic [COUNT_W-1:0] count_q;

	logic               accept;
	logic [VOXEL_W-1:0] v;
	logic [VOXEL_W-1:0] empty;
	logic               occupied;
	logic               final_cell;
	logic               mismatch;
	logic               uni_next;
	logic [MASK_W-1:0]  mask_next;
	logic [COUNT_W-1:0] count_next;
	logic [VOXEL_W-1:0] first_next;
	vboe_result_t       entry;
	vboe_result_t       summary;
	vboe_push_t         push;
	vboe_result_t       head;
	logic               head_valid;
	logic               room;
	logic               cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_EMPTY_CODE) ? {16'd0, empty_code_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_code_q <= '0;
		end else if (cfg_write && paddr[2] == REG_EMPTY_CODE) begin
			empty_code_q <= pwdata[VOXEL_W-1:0];
		end
	end

	assign voxels.ready = room;
	assign accept       = voxels.valid && room;

	always_comb begin
		v          = voxels.voxel & VMASK;
		empty      = empty_code_q & VMASK;
		occupied   = (v != empty);
		final_cell = (position_q == LAST_POS);
		mismatch   = occupied && (count_q != '0) && (first_q != v);
		uni_next   = still_uniform_q && !mismatch;
		mask_next  = mask_q | (occupied ? (MASK_W'(1) << position_q) : '0);
		count_next = count_q + COUNT_W'(occupied);
		first_next = (occupied && count_q == '0) ? v : first_q;

		entry                  = '0;
		entry.kind             = KIND_PACKED;
		entry.packed_value     = v;
		entry.packed_index     = count_q[INDEX_W-1:0];
		entry.last             = !final_cell;

		summary                 = '0;
		summary.kind            = KIND_SUMMARY;
		summary.occupancy       = mask_next;
		summary.occupied_count  = count_next;
		summary.single_material = uni_next;
		summary.brick_material  = (count_next == '0) ? empty_code_q : first_next;
		summary.node_flags      = uni_next ? FLAGS_UNIFORM : FLAGS_LIST;
		summary.last            = 1'b1;

		push.n      = accept ? (2'(occupied) + 2'(final_cell)) : 2'd0;
		push.first  = occupied ? entry : summary;
		push.second = summary;
	end

	always_ff @(posedge clk) begin
		if (accept && occupied && count_q == '0) begin
			first_q <= v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q      <= '0;
			mask_q          <= '0;
			still_uniform_q <= 1'b1;
			count_q         <= '0;
		end else if (accept) begin
			if (final_cell) begin
				position_q      <= '0;
				mask_q          <= '0;
				still_uniform_q <= 1'b1;
				count_q         <= '0;
			end else begin
				position_q      <= position_q + INDEX_W'(1);
				mask_q          <= mask_next;
				still_uniform_q <= uni_next;
				count_q         <= count_next;
			end
		end
	end

	vboe_result_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.head_valid (head_valid),
		.head       (head),
		.pop        (results.ready)
	);

	assign results.valid           = head_valid;
	assign results.kind            = head.kind;
	assign results.packed_value    = head.packed_value;
	assign results.packed_index    = head.packed_index;
	assign results.occupancy       = head.occupancy;
	assign results.occupied_count  = head.occupied_count;
	assign results.single_material = head.single_material;
	assign results.brick_material  = head.brick_material;
	assign results.node_flags      = head.node_flags;
	assign results.last            = head.last;

	a_brick_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && final_cell) |=> (position_q == '0 && count_q == '0 && mask_q == '0))
		else $error("brick state not cleared after the last voxel");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(position_q))
		else $error("occupied count exceeds voxels taken");

	a_summary_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.kind == KIND_SUMMARY) |->
		(results.last && (results.single_material ? results.node_flags == FLAGS_UNIFORM
			: results.node_flags == FLAGS_LIST)))
		else $error("summary flags inconsistent");

	a_no_push_without_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> room)
		else $error("result queue written without room");

endmodule

`default_nettype wire

// File: hw/rtl/vboe_result_fifo.sv
// Small result queue that takes up to two results per cycle and returns one.
`default_nettype none

module vboe_result_fifo
	import vboe_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire vboe_push_t   push,
	output logic              room,
	output logic              head_valid,
	output vboe_result_t      head,
	input  wire logic         pop
);

	vboe_result_t mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_pop;

	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign room       = (cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_q + FIFO_PTR_W'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push.n);
			rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(do_pop);
			cnt_q    <= cnt_q + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(do_pop);
		end
	end

endmodule

`default_nettype wire
